FILE: rtl/spp_pkg.sv
// Shared constants and controller/datapath interface types for the stable partition block.
package spp_pkg;

    // Number of upper-side values that can be held until the end of a sequence
    localparam int unsigned BufferDepth = 32;
    localparam int unsigned DataW       = 32;
    localparam int unsigned CntW        = $clog2(BufferDepth + 1);
    localparam int unsigned AddrW       = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

    // APB register map: one register per 4-byte word
    localparam int unsigned ApbAw      = 3;
    localparam logic [0:0]  REG_PIVOT  = 1'b0;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic rd_issue;    // read buffer entry at the drain pointer
        logic drain_load;  // move read data into the output register
        logic clear;       // end of sequence: empty buffer, clear drop flag
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register can take a new beat
        logic in_last;     // incoming beat closes the sequence
        logic held_after;  // buffer is non-empty once the incoming beat is handled
        logic drain_last;  // drain pointer is at the last held entry
    } t_sts;

endpackage

FILE: rtl/stable_partition_by_pivot.sv
// Top level of the stable partition block: stream ports, APB port, controller and datapath.
//
// Usage:
//   A sequence of signed 32-bit values arrives on the s_ stream, one per beat, with
//   s_tlast on the final one. Values strictly below the pivot register (APB address 0)
//   leave on the m_ stream in the cycle after intake, in order. All other values are held
//   in a 32-entry buffer; when the final beat has been taken they leave in arrival
//   order, and the very last output beat of the sequence carries m_tlast. m_tuser is the
//   sticky overflow flag: set once an upper value was dropped on a full buffer, cleared
//   at the end of the sequence.
// Throughput:
//   One input beat per cycle while the output side keeps up; a lower value appears on
//   the output in the cycle after it is taken. After the final beat, intake stops while
//   the buffer drains: each held value is read from memory, then moved into the output
//   register, and input stays blocked until the last held value has been loaded.
// Reset: synchronous, active low; clears the pivot to 0, empties the buffer and
//   drops any pending output beat.
// Stall: while m_tready is low the output register holds its beat; intake and the
//   drain both wait on it, so no beat is lost.
// Configuration writes are to be made only while the block is idle.
module stable_partition_by_pivot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spp_pkg::ApbAw-1:0]     paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spp_pkg::DataW-1:0]     s_tdata,   // [31:0] value
    input  logic                          s_tlast,   // last_item
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spp_pkg::DataW-1:0]     m_tdata,   // [31:0] out_value
    output logic                          m_tlast,   // end_of_list
    output logic                          m_tuser    // [0] overflow
);

    spp_pkg::t_cmd cmd;
    spp_pkg::t_sts sts;

    assign pready = 1'b1;

    spp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    spp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_value     (s_tdata),
        .i_last      (s_tlast),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_value (m_tdata),
        .o_out_end   (m_tlast),
        .o_out_ovf   (m_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: rtl/spp_ctrl.sv
// Sequencing state machine: stream intake and end-of-sequence buffer drain.
module spp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  spp_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output spp_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.in_last) begin
                    if (i_sts.held_after) begin
                        n_state = ST_READ;
                    end else begin
                        o_cmd.clear = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_SEND;
            end
            ST_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.drain_load = 1'b1;
                    if (i_sts.drain_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/spp_dpath.sv
// Datapath: pivot register, compare, upper-value buffer, counters and output register.
module spp_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spp_pkg::ApbAw-1:0]            paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    // input beat payload
    input  logic [spp_pkg::DataW-1:0]            i_value,
    input  logic                                 i_last,
    // output beat
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [spp_pkg::DataW-1:0]            o_out_value,
    output logic                                 o_out_end,
    output logic                                 o_out_ovf,
    // controller link
    input  spp_pkg::t_cmd                        i_cmd,
    output spp_pkg::t_sts                        o_sts
);

    logic [spp_pkg::DataW-1:0] r_pivot;
    logic [spp_pkg::DataW-1:0] r_mem [spp_pkg::BufferDepth];
    logic [spp_pkg::DataW-1:0] r_rdata;
    logic [spp_pkg::CntW-1:0]  r_count;
    logic [spp_pkg::AddrW-1:0] r_ptr;
    logic                      r_drop;
    logic                      r_out_valid;
    logic [spp_pkg::DataW-1:0] r_out_value;
    logic                      r_out_end;
    logic                      r_out_ovf;

    logic                      upper;
    logic                      has_room;
    logic                      out_free;
    logic                      cfg_wr;
    logic [spp_pkg::CntW-1:0]  ptr_next;

    assign upper    = !($signed(i_value) < $signed(r_pivot));
    assign has_room = r_count < spp_pkg::CntW'(spp_pkg::BufferDepth);
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign ptr_next = spp_pkg::CntW'(r_ptr) + spp_pkg::CntW'(1);

    assign o_sts.out_free   = out_free;
    assign o_sts.in_last    = i_last;
    assign o_sts.held_after = (r_count != '0) || upper;
    assign o_sts.drain_last = (ptr_next == r_count);

    // Pivot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot <= '0;
        end else if (cfg_wr && paddr[2] == spp_pkg::REG_PIVOT) begin
            r_pivot <= pwdata;
        end
    end

    assign prdata = (paddr[2] == spp_pkg::REG_PIVOT) ? r_pivot : 32'd0;

    // Buffer memory: write at fill level, registered read at drain pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && upper && has_room) begin
            r_mem[r_count[spp_pkg::AddrW-1:0]] <= i_value;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    // Fill level, sticky drop flag and drain pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_ptr <= '0;
                if (upper && has_room) begin
                    r_count <= r_count + spp_pkg::CntW'(1);
                end else if (upper) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.drain_load) begin
                r_ptr <= ptr_next[spp_pkg::AddrW-1:0];
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    // Output register: lower values pass at intake, held values during drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !upper) || i_cmd.drain_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !upper) begin
            r_out_value <= i_value;
            r_out_end   <= i_last && (r_count == '0);
            r_out_ovf   <= r_drop;
        end else if (i_cmd.drain_load) begin
            r_out_value <= r_rdata;
            r_out_end   <= o_sts.drain_last;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_end   = r_out_end;
    assign o_out_ovf   = r_out_ovf;

    // Fill level never passes the buffer depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spp_pkg::CntW'(spp_pkg::BufferDepth))
        else $error("buffer fill level beyond depth");

    // A drop only happens with a full buffer
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> r_count == spp_pkg::CntW'(spp_pkg::BufferDepth))
        else $error("drop flag set with room in buffer");

    // End of sequence leaves the buffer empty and the drop flag clear
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0) && !r_drop)
        else $error("sequence end did not clear state");

    // A final lower value with nothing held closes the sequence at once
    a_direct_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && !upper && i_last && r_count == '0) |=> r_out_valid && r_out_end)
        else $error("final lower value not marked end of list");

    // Drain never overwrites a beat that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain_load |-> out_free)
        else $error("output beat overwritten");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for stable_partition_by_pivot: directed table plus random sequences.
module testbench;

    typedef struct packed {
        logic [31:0] value;
        logic        eol;
        logic        ovf;
    } t_part_beat;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_PIVOT,
        ROW_SPARE_REG
    } t_row_kind;

    // one stimulus row: a beat, or a register write (value holds the write data)
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;
        logic        last;
        logic        typed;
        t_part_beat  want;
    } t_dir_row;

    localparam int unsigned PivotReg = 32'(spp_pkg::REG_PIVOT);
    localparam int unsigned SpareReg = 1;   // index past the register map, write ignored
    localparam logic signed [31:0] MinV = 32'sh8000_0000;
    localparam logic signed [31:0] MaxV = 32'sh7FFF_FFFF;
    localparam t_part_beat NoBeat = '0;
    localparam int NumRows = 23;
    localparam int NumPhases = 6;
    localparam int PhaseItems = 62;
    localparam int DrainBound = 20000;

    // value bias for random items
    localparam int BiasAny = 0;
    localparam int BiasUpper = 1;
    localparam int BiasLower = 2;

    // directed rows; typed expectations only where the result is obvious
    localparam t_dir_row DirRows [NumRows] = '{
        '{ROW_BEAT,  32'h8000_0000, 1'b0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
        '{ROW_BEAT,  32'h7FFF_FFFF, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'hFFFF_FFFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{ROW_BEAT,  32'h0000_0000, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h0000_0001, 1'b1, 1'b0, NoBeat},
        // lower final value with nothing held closes the list itself
        '{ROW_BEAT,  32'hFFFF_FFFB, 1'b1, 1'b1, '{32'hFFFF_FFFB, 1'b1, 1'b0}},
        // upper final value alone
        '{ROW_BEAT,  32'h0000_0007, 1'b1, 1'b0, NoBeat},
        '{ROW_BEAT,  32'hFFFF_FFFD, 1'b0, 1'b1, '{32'hFFFF_FFFD, 1'b0, 1'b0}},
        '{ROW_BEAT,  32'h0000_0005, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'hFFFF_FFF7, 1'b1, 1'b0, NoBeat},
        // pivot at the minimum: nothing is below it
        '{ROW_PIVOT, 32'h8000_0000, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h8000_0000, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'hFFFF_FFFF, 1'b1, 1'b0, NoBeat},
        // pivot at the maximum: only the maximum is held
        '{ROW_PIVOT, 32'h7FFF_FFFF, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h7FFF_FFFF, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h7FFF_FFFE, 1'b0, 1'b1, '{32'h7FFF_FFFE, 1'b0, 1'b0}},
        '{ROW_BEAT,  32'h8000_0000, 1'b1, 1'b0, NoBeat},
        // write past the map must leave the pivot alone
        '{ROW_SPARE_REG, 32'h1234_5678, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h7FFF_FFFE, 1'b1, 1'b1, '{32'h7FFF_FFFE, 1'b1, 1'b0}},
        '{ROW_PIVOT, 32'h0000_0064, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h0000_0064, 1'b0, 1'b0, NoBeat},
        '{ROW_BEAT,  32'h0000_0063, 1'b0, 1'b1, '{32'h0000_0063, 1'b0, 1'b0}},
        '{ROW_BEAT,  32'h0000_0065, 1'b1, 1'b0, NoBeat}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [spp_pkg::ApbAw-1:0]   paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [spp_pkg::DataW-1:0]   s_tdata;   // [31:0] value
    logic                        s_tlast;   // last_item
    logic                        m_tvalid;
    logic                        m_tready;
    logic [spp_pkg::DataW-1:0]   m_tdata;   // [31:0] out_value
    logic                        m_tlast;   // end_of_list
    logic                        m_tuser;   // [0] overflow

    // predictor state
    logic signed [31:0]  cur_pivot;
    logic [31:0]         held_upper[$];
    logic                upper_dropped;
    t_part_beat          expected_beats[$];

    int                  mismatch_count = 0;
    logic                quiet = 1'b0;   // no idling on either side while set

    stable_partition_by_pivot DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [spp_pkg::ApbAw-1:0] reg_addr(input int unsigned idx);
        return spp_pkg::ApbAw'(idx * 4);
    endfunction

    // stable partition predictor: lower values pass, upper values wait for the final beat
    task automatic predict_partition(input logic [31:0] value, input logic last);
        t_part_beat b;
        int i;
        if ($signed(value) < cur_pivot) begin
            b.value = value;
            b.eol   = last && (held_upper.size() == 0);
            b.ovf   = upper_dropped;
            expected_beats.push_back(b);
        end else if (held_upper.size() < spp_pkg::BufferDepth) begin
            held_upper.push_back(value);
        end else begin
            upper_dropped = 1'b1;
        end
        if (last) begin
            for (i = 0; i < held_upper.size(); i++) begin
                b.value = held_upper[i];
                b.eol   = (i == held_upper.size() - 1);
                b.ovf   = upper_dropped;
                expected_beats.push_back(b);
            end
            held_upper.delete();
            upper_dropped = 1'b0;
        end
    endtask

    // random value around the current pivot
    function automatic logic [31:0] pick_value(input int bias);
        longint lo;
        longint hi;
        longint unsigned span;
        longint unsigned off;
        int r;
        int b;
        b = bias;
        r = $urandom_range(0, 99);
        if (b == BiasAny) begin
            if (r < 50) return $urandom;
            if (r < 65) begin
                case ($urandom_range(0, 3))
                    0: return MinV;
                    1: return MaxV;
                    2: return cur_pivot;
                    default: return cur_pivot - 1;
                endcase
            end
            b = (r < 85) ? BiasUpper : BiasLower;
        end
        if (b == BiasLower && cur_pivot == MinV) b = BiasUpper;
        if (b == BiasUpper) begin
            lo = longint'(cur_pivot);
            hi = longint'(MaxV);
        end else begin
            lo = longint'(MinV);
            hi = longint'(cur_pivot) - 1;
        end
        // boundary values now and then
        if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 0) ? 32'(lo) : 32'(hi);
        span = longint'(hi - lo + 1);
        off  = {$urandom, $urandom} % span;
        return 32'(lo + longint'(off));
    endfunction

    task automatic apb_write(input logic [spp_pkg::ApbAw-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [spp_pkg::ApbAw-1:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_pivot_readback();
        logic [31:0] rd;
        apb_read(reg_addr(PivotReg), rd);
        if (rd !== cur_pivot) begin
            $display("%0t: pivot readback expected %h actual %h", $time, cur_pivot, rd);
            mismatch_count++;
        end
    endtask

    // wait for every expected beat, bounded
    task automatic wait_drained();
        int waited;
        waited = 0;
        while (expected_beats.size() > 0 && waited < DrainBound) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_beats.size() > 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
            mismatch_count++;
            expected_beats.delete();
        end
    endtask

    // register write with the block idle, then read back the pivot
    task automatic write_reg(input int unsigned idx, input logic [31:0] data);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        apb_write(reg_addr(idx), data);
        if (idx == PivotReg) cur_pivot = data;
        check_pivot_readback();
    endtask

    // one input beat; predicts at the handshake
    task automatic send_item(input logic [31:0] value, input logic last,
                             input logic typed, input t_part_beat typed_beat);
        int gap;
        int n_before;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        n_before = expected_beats.size();
        predict_partition(value, last);
        if (typed) begin
            if (expected_beats.size() != n_before + 1) begin
                $display("%0t: row %h should give one beat, predictor gives %0d", $time, value,
                         expected_beats.size() - n_before);
                mismatch_count++;
            end else begin
                expected_beats[$] = typed_beat;
            end
        end
    endtask

    // output side: ready runs with random stalls
    initial begin
        int run;
        int stall;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            run = $urandom_range(1, 12);
            @(negedge i_clk);
            m_tready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // compare each output beat with the oldest expectation
    always @(posedge i_clk) begin : watch_out
        t_part_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat expected none actual %h last %b ovf %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: out_value expected %h actual %h", $time, want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.eol) begin
                    $display("%0t: end_of_list expected %b actual %b", $time, want.eol, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time, want.ovf, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [31:0] rd;
        logic signed [31:0] phase_pivot;
        int ph;
        int k;
        int len;
        int items;
        int bias;
        logic fill;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cur_pivot     = '0;
        upper_dropped = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pivot comes out of reset at zero
        apb_read(reg_addr(PivotReg), rd);
        if (rd !== 32'h0000_0000) begin
            $display("%0t: reset pivot expected %h actual %h", $time, 32'h0000_0000, rd);
            mismatch_count++;
        end

        // directed table
        for (k = 0; k < NumRows; k++) begin
            case (DirRows[k].kind)
                ROW_BEAT: begin
                    send_item(DirRows[k].value, DirRows[k].last, DirRows[k].typed,
                              DirRows[k].want);
                end
                ROW_PIVOT: begin
                    write_reg(PivotReg, DirRows[k].value);
                end
                default: begin
                    write_reg(SpareReg, DirRows[k].value);
                end
            endcase
        end

        // random phases, one pivot each, always ending on a closed sequence
        for (ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: phase_pivot = MinV;
                2: phase_pivot = MaxV;
                3: phase_pivot = '0;
                4: phase_pivot = $signed(32'($urandom_range(0, 200))) - 100;
                default: phase_pivot = $urandom;
            endcase
            quiet = 1'b0;
            write_reg(PivotReg, phase_pivot);
            items = 0;
            while (items < PhaseItems) begin
                // fill sequences run near or past the buffer depth, mostly upper values, to force drops
                fill  = ($urandom_range(0, 4) == 0);
                len   = fill ? $urandom_range(spp_pkg::BufferDepth - 2,
                                              spp_pkg::BufferDepth + 6)
                             : $urandom_range(1, 10);
                quiet = ($urandom_range(0, 4) == 0);
                for (k = 0; k < len; k++) begin
                    if (fill) bias = ($urandom_range(0, 9) == 0) ? BiasLower : BiasUpper;
                    else bias = BiasAny;
                    send_item(pick_value(bias), k == len - 1, 1'b0, NoBeat);
                end
                items += len;
            end
        end

        quiet = 1'b0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: stable_partition_by_pivot.f
rtl/spp_pkg.sv
rtl/spp_ctrl.sv
rtl/spp_dpath.sv
rtl/stable_partition_by_pivot.sv
dv/testbench.sv
